// ===== design/htfd_pkg.sv =====
package htfd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // 175 and 100 scaled to hundredths, doubled so that the rounding bias is the odd divisor
   localparam logic [15:0] TEMP_SCALE = 16'd35000;
   localparam logic [15:0] HUM_SCALE = 16'd20000;
   localparam logic [31:0] ROUND_BIAS = 32'd65535;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;

   typedef enum logic [2:0] {
      POS_TEMP_HI,
      POS_TEMP_LO,
      POS_TEMP_CRC,
      POS_HUM_HI,
      POS_HUM_LO,
      POS_HUM_CRC
   } pos_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_TEMP_CRC,
      STATUS_HUM_CRC
   } status_type;

   typedef struct packed {
      logic [15:0] temperature_raw;
      logic [15:0] humidity_raw;
      status_type  frame_status;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_beat_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== design/htfd_front.sv =====
module htfd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    frame_start,
   output htfd_pkg::frame_beat_type push
);
   import htfd_pkg::*;

   pos_type     pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] tword_ff, tword_in;
   logic        tgood_ff, tgood_in;
   logic [7:0]  hhi_ff, hhi_in;
   logic [7:0]  hlo_ff, hlo_in;
   status_type  status;

   // a start flag takes the byte as the first of a new frame
   assign pos_eff = frame_start ? POS_TEMP_HI : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         case (pos_eff)
            POS_TEMP_LO:  pos_in = POS_TEMP_CRC;
            POS_TEMP_CRC: pos_in = POS_HUM_HI;
            POS_HUM_HI:   pos_in = POS_HUM_LO;
            POS_HUM_LO:   pos_in = POS_HUM_CRC;
            POS_HUM_CRC:  pos_in = POS_TEMP_HI;
            default:      pos_in = POS_TEMP_LO;
         endcase
      end
   end

   always_comb begin
      if (!tgood_ff) begin
         status = STATUS_TEMP_CRC;
      end else if (crc_ff != data_byte) begin
         status = STATUS_HUM_CRC;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      crc_in = crc_ff;
      tword_in = tword_ff;
      tgood_in = tgood_ff;
      hhi_in = hhi_ff;
      hlo_in = hlo_ff;
      push.valid = 1'b0;
      push.frame.temperature_raw = tword_ff;
      push.frame.humidity_raw = {hhi_ff, hlo_ff};
      push.frame.frame_status = status;
      if (accept) begin
         case (pos_eff)
            POS_TEMP_LO: begin
               crc_in = crc8_step(crc_ff, data_byte);
               tword_in[7:0] = data_byte;
            end
            POS_TEMP_CRC: begin
               tgood_in = (crc_ff == data_byte);
               crc_in = CRC_INIT;
            end
            POS_HUM_HI: begin
               crc_in = crc8_step(crc_ff, data_byte);
               hhi_in = data_byte;
            end
            POS_HUM_LO: begin
               crc_in = crc8_step(crc_ff, data_byte);
               hlo_in = data_byte;
            end
            POS_HUM_CRC: begin
               push.valid = 1'b1;
               crc_in = CRC_INIT;
            end
            default: begin
               crc_in = crc8_step(CRC_INIT, data_byte);
               tword_in = {data_byte, 8'h00};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_TEMP_HI;
         crc_ff <= CRC_INIT;
         tgood_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         tgood_ff <= tgood_in;
      end
   end

   always_ff @(posedge clock) begin
      tword_ff <= tword_in;
      hhi_ff <= hhi_in;
      hlo_ff <= hlo_in;
   end

endmodule

// ===== design/htfd_queue.sv =====
module htfd_queue #(
   parameter int DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  htfd_pkg::frame_beat_type push,
   output logic                     full,
   output htfd_pkg::frame_beat_type head,
   input  logic                     pop
);
   import htfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   frame_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.frame = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

// ===== design/htfd_back.sv =====
module htfd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  htfd_pkg::frame_beat_type head,
   output logic                     pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [15:0]              rsp_temperature_raw,
   output logic [15:0]              rsp_humidity_raw,
   output logic signed [14:0]       rsp_temperature_centi,
   output logic [13:0]              rsp_humidity_centi,
   output logic [1:0]               rsp_frame_status
);
   import htfd_pkg::*;

   // round(prod / 131070): halve, then divide by 65535 with a shift-add that is exact below 2^31
   function automatic logic [15:0] div_round(input logic [31:0] prod);
      logic [31:0] n;
      logic [31:0] m;
      logic [31:0] s;
      n = prod + ROUND_BIAS;
      m = {1'b0, n[31:1]};
      s = m + {16'h0000, m[31:16]} + 32'd1;
      return s[31:16];
   endfunction

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_tprod_ff, s1_tprod_in;
   logic [30:0] s1_hprod_ff, s1_hprod_in;
   logic [15:0] s1_traw_ff, s1_traw_in;
   logic [15:0] s1_hraw_ff, s1_hraw_in;
   status_type  s1_status_ff, s1_status_in;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_traw_ff, out_traw_in;
   logic [15:0] out_hraw_ff, out_hraw_in;
   logic [14:0] out_tc_ff, out_tc_in;
   logic [13:0] out_hc_ff, out_hc_in;
   status_type  out_status_ff, out_status_in;

   logic        advance;
   logic        s1_ready;
   logic [31:0] hprod_full;
   logic [15:0] tq, hq;

   assign advance = !out_valid_ff || rsp_pop;
   assign s1_ready = !s1_valid_ff || advance;
   assign pop = head.valid && s1_ready;

   assign hprod_full = {16'h0000, head.frame.humidity_raw} * {16'h0000, HUM_SCALE};
   assign tq = div_round(s1_tprod_ff);
   assign hq = div_round({1'b0, s1_hprod_ff});

   always_comb begin
      s1_valid_in = s1_ready ? pop : s1_valid_ff;
      s1_tprod_in = s1_tprod_ff;
      s1_hprod_in = s1_hprod_ff;
      s1_traw_in = s1_traw_ff;
      s1_hraw_in = s1_hraw_ff;
      s1_status_in = s1_status_ff;
      if (pop) begin
         s1_tprod_in = {16'h0000, head.frame.temperature_raw} * {16'h0000, TEMP_SCALE};
         s1_hprod_in = hprod_full[30:0];
         s1_traw_in = head.frame.temperature_raw;
         s1_hraw_in = head.frame.humidity_raw;
         s1_status_in = head.frame.frame_status;
      end
   end

   always_comb begin
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
      out_traw_in = out_traw_ff;
      out_hraw_in = out_hraw_ff;
      out_tc_in = out_tc_ff;
      out_hc_in = out_hc_ff;
      out_status_in = out_status_ff;
      if (advance && s1_valid_ff) begin
         out_traw_in = s1_traw_ff;
         out_hraw_in = s1_hraw_ff;
         // wraps to two's complement below zero
         out_tc_in = tq[14:0] - TEMP_OFFSET;
         out_hc_in = hq[13:0];
         out_status_in = s1_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tprod_ff <= s1_tprod_in;
      s1_hprod_ff <= s1_hprod_in;
      s1_traw_ff <= s1_traw_in;
      s1_hraw_ff <= s1_hraw_in;
      s1_status_ff <= s1_status_in;
      out_traw_ff <= out_traw_in;
      out_hraw_ff <= out_hraw_in;
      out_tc_ff <= out_tc_in;
      out_hc_ff <= out_hc_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_temperature_raw = out_traw_ff;
   assign rsp_humidity_raw = out_hraw_ff;
   assign rsp_temperature_centi = $signed(out_tc_ff);
   assign rsp_humidity_centi = out_hc_ff;
   assign rsp_frame_status = out_status_ff;

endmodule

// ===== design/humidity_temperature_frame_decoder_top.sv =====
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// request   | req_data_byte, req_frame_start          | beat on req_push && !req_full
// response  | rsp_temperature_raw, rsp_humidity_raw,  | beat on rsp_pop && !rsp_empty
//           | rsp_temperature_centi,                  |
//           | rsp_humidity_centi, rsp_frame_status    |
//
// One byte is taken every cycle while req_full is low; CRC-8 of each byte is computed combinationally.
// The frame closed by its sixth byte enters a frame queue and reaches the response ports
// through the queue, the multiplier stage and the divide-and-round output register.
// req_full rises only while the frame queue is full; the response side stalls on its own.
// Synchronous reset empties the queue and pipeline and restarts the frame at byte zero.
module humidity_temperature_frame_decoder_top #(
   parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_start,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_temperature_raw,
   output logic [15:0]        rsp_humidity_raw,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [1:0]         rsp_frame_status
);
   import htfd_pkg::*;

   logic           accept;
   frame_beat_type fe_push;
   frame_beat_type q_head;
   logic           q_pop;

   assign accept = req_push && !req_full;

   htfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .push        (fe_push)
   );

   htfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fe_push),
      .full  (req_full),
      .head  (q_head),
      .pop   (q_pop)
   );

   htfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (q_head),
      .pop                   (q_pop),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_humidity_raw      (rsp_humidity_raw),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_frame_status      (rsp_frame_status)
   );

   a_push_on_beat: assert property (@(posedge clock) disable iff (reset)
      fe_push.valid |-> accept)
      else $error("frame pushed without a request beat");

   a_start_no_push: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_start) |-> !fe_push.valid)
      else $error("start byte closed a frame");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("back end popped an empty queue");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("response pending right after reset");

endmodule
